### design/asbs_pkg.sv
// asbs_pkg: widths, fixed-point constants and types for the arcsine slew bus summer.
// No dependencies; used by the interfaces, the sine pipeline, the top level and the checker.

package asbs_pkg;

  // sample scale: 1.0 = 2^FRAC
  localparam int SAMPLE_BITS = 24;
  localparam int FRAC        = SAMPLE_BITS - 1;
  localparam int OUT_W       = SAMPLE_BITS + 1;
  localparam int ANGLE_W     = SAMPLE_BITS + 1;
  localparam int SINE_W      = SAMPLE_BITS;
  localparam int SUM_W       = SAMPLE_BITS + 2;

  // sine polynomial datapath, Q30
  localparam int Q30_SHIFT = 30 - FRAC;
  localparam int ONE_SH    = 30;
  localparam int T_W       = ANGLE_W + Q30_SHIFT;
  localparam int U_W       = 32;
  localparam int P_W       = 32;
  localparam int R_W       = 31;
  localparam int Q_W       = 30;
  localparam int V_W       = 33;
  localparam int MAGIC_W   = 33;
  localparam int NUM_DIV   = 6;
  localparam int unsigned SINE_DIV [NUM_DIV] = '{156, 110, 72, 42, 20, 6};

  // arcsine bit search, bits FRAC+1 down to 0
  localparam int NUM_TRIALS = FRAC + 2;

  localparam longint unsigned HALF_PI_Q40 = 64'd1727108829703;
  localparam int HP_SHIFT = 40 - FRAC;
  localparam logic [ANGLE_W-1:0] HALF_PI =
    ANGLE_W'((HALF_PI_Q40 + (64'd1 << (HP_SHIFT - 1))) >> HP_SHIFT);
  localparam logic [SINE_W-1:0] SINE_ONE = SINE_W'(1) << FRAC;

  // centering gain register
  localparam int GAIN_W         = 17;
  localparam int GAIN_FRAC_BITS = 16;
  localparam logic [GAIN_W-1:0] GAIN_ONE   = GAIN_W'(1) << GAIN_FRAC_BITS;
  localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(65536);

  // configuration port
  localparam int DATA_W    = 32;
  localparam int ADDR_W    = 3;
  localparam int REG_IDX_W = ADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_GAIN = REG_IDX_W'(0);

  typedef logic signed [SAMPLE_BITS-1:0] sample_in_t;
  typedef logic signed [OUT_W-1:0]       sample_out_t;
  typedef logic [ANGLE_W-1:0]            angle_t;
  typedef logic [SINE_W-1:0]             sine_t;

endpackage

### design/asbs_if.sv
// Request channels of the arcsine slew bus summer: sample in, sample out.
// Depends on asbs_pkg for the payload types.

interface asbs_in_if;
  logic                  valid;
  logic                  ready;
  asbs_pkg::sample_in_t  sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

interface asbs_out_if;
  logic                  valid;
  logic                  ready;
  asbs_pkg::sample_out_t sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

### design/asbs_sine.sv
// asbs_sine: 14-stage pipelined sine of a nonnegative angle up to pi/2, sample scale.
// Square, six Horner steps (multiply, then divide by constant via reciprocal), final multiply.
// Depends on asbs_pkg. Sideband of SIDE_W bits travels alongside.

module asbs_sine #(
  parameter int SIDE_W = 1
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic                     in_valid,
  input  asbs_pkg::angle_t         in_angle,
  input  logic [SIDE_W-1:0]        in_side,
  output logic                     out_valid,
  output asbs_pkg::sine_t          out_sine,
  output logic [SIDE_W-1:0]        out_side
);

  localparam int N     = asbs_pkg::NUM_DIV;
  localparam int T_W   = asbs_pkg::T_W;
  localparam int U_W   = asbs_pkg::U_W;
  localparam int P_W   = asbs_pkg::P_W;
  localparam int R_W   = asbs_pkg::R_W;
  localparam int Q_W   = asbs_pkg::Q_W;
  localparam int V_W   = asbs_pkg::V_W;
  localparam int M_W   = asbs_pkg::MAGIC_W;
  localparam int SQ_W  = 2 * T_W;
  localparam int PA_W  = U_W + R_W;
  localparam int PB_W  = P_W + M_W;
  localparam int PF_W  = T_W + R_W;
  localparam int RND_W = V_W + 1;
  localparam logic [R_W-1:0]   ONE_Q30    = R_W'(1) << asbs_pkg::ONE_SH;
  localparam logic [RND_W-1:0] ROUND_HALF = RND_W'(1) << (asbs_pkg::Q30_SHIFT - 1);

  // position i holds the state before Horner step i
  logic              pos_valid [0:N];
  logic [T_W-1:0]    pos_t     [0:N];
  logic [R_W-1:0]    pos_r     [0:N];
  logic [SIDE_W-1:0] pos_side  [0:N];
  logic [U_W-1:0]    pos_u     [0:N-1];

  logic              mid_valid [0:N-1];
  logic [T_W-1:0]    mid_t     [0:N-1];
  logic [P_W-1:0]    mid_p     [0:N-1];
  logic [SIDE_W-1:0] mid_side  [0:N-1];
  logic [U_W-1:0]    mid_u     [0:N-2];

  logic [T_W-1:0]    t_in;
  logic [SQ_W-1:0]   sq;
  logic [PF_W-1:0]   prod_f;
  logic [V_W-1:0]    v_f;
  logic [RND_W-1:0]  rnd_f;
  logic [RND_W-1:0]  s_f;

  always_comb begin
    t_in = {in_angle, {asbs_pkg::Q30_SHIFT{1'b0}}};
    sq   = SQ_W'(t_in) * SQ_W'(t_in);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_valid[0] <= 1'b0;
    end else if (en) begin
      pos_valid[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pos_t[0]    <= t_in;
      pos_u[0]    <= U_W'(sq >> asbs_pkg::ONE_SH);
      pos_r[0]    <= ONE_Q30;
      pos_side[0] <= in_side;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_step
    localparam int unsigned DIV_K = asbs_pkg::SINE_DIV[i];
    localparam int DIV_SH = P_W + $clog2(DIV_K);
    localparam logic [M_W-1:0] DIV_MAGIC =
      M_W'(((64'd1 << DIV_SH) + 64'(DIV_K) - 64'd1) / 64'(DIV_K));

    logic [PA_W-1:0] prod_a;
    logic [PB_W-1:0] prod_b;

    always_comb begin
      prod_a = PA_W'(pos_u[i]) * PA_W'(pos_r[i]);
      prod_b = PB_W'(mid_p[i]) * PB_W'(DIV_MAGIC);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        mid_valid[i]   <= 1'b0;
        pos_valid[i+1] <= 1'b0;
      end else if (en) begin
        mid_valid[i]   <= pos_valid[i];
        pos_valid[i+1] <= mid_valid[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        mid_p[i]      <= P_W'(prod_a >> asbs_pkg::ONE_SH);
        mid_t[i]      <= pos_t[i];
        mid_side[i]   <= pos_side[i];
        pos_t[i+1]    <= mid_t[i];
        pos_side[i+1] <= mid_side[i];
        pos_r[i+1]    <= ONE_Q30 - R_W'(Q_W'(prod_b >> DIV_SH));
      end
    end

    if (i < N - 1) begin : g_carry_u
      always_ff @(posedge clk) begin
        if (en) begin
          mid_u[i]   <= pos_u[i];
          pos_u[i+1] <= mid_u[i];
        end
      end
    end
  end

  always_comb begin
    prod_f = PF_W'(pos_t[N]) * PF_W'(pos_r[N]);
    v_f    = V_W'(prod_f >> asbs_pkg::ONE_SH);
    rnd_f  = RND_W'(v_f) + ROUND_HALF;
    s_f    = rnd_f >> asbs_pkg::Q30_SHIFT;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= pos_valid[N];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_side <= pos_side[N];
      out_sine <= (s_f > RND_W'(asbs_pkg::SINE_ONE)) ? asbs_pkg::SINE_ONE
                                                      : asbs_pkg::SINE_W'(s_f);
    end
  end

endmodule

### design/arcsine_slew_bus_summer_unit.sv
// Top level of the arcsine slew bus summer: arcsine bit search, slew sine, feedback sum.
// Depends on asbs_pkg, asbs_if (asbs_in_if, asbs_out_if) and asbs_sine.
//
// Usage:
//   din  carries one signed sample per request (sample_in, 1.0 = 2^23).
//   dout carries one result per request (sample_out, 25 bits, range +-2, top saturated).
//   The APB port holds centering_gain at byte address 0 (Q16, 65536 = no centering);
//   write it only while no request is in flight. pready is always high.
// Pipeline: the arcsine takes 25 bit trials, each a 14-stage sine pipeline plus a
//   decision register; then a register for the angle difference, a further sine
//   pipeline for its sine and the output register for the feedback sum.
// Throughput: one request per cycle unless the output and skid registers both hold
//   results; the feedback sum is combinational, feedback_level updates per result.
// Reset (rst, synchronous): clears previous angle and feedback level, sets the gain
//   to 65536 and empties the pipeline; din.ready stays low during reset.
// Stall: the whole pipeline advances together. A result that meets a stalled
//   receiver lands in a skid register, so din.ready drops only while both the
//   output register and the skid register hold results.

module arcsine_slew_bus_summer_unit (
  input  logic                              clk,
  input  logic                              rst,
  asbs_in_if.sink                           din,
  asbs_out_if.source                        dout,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [asbs_pkg::ADDR_W-1:0]       paddr,
  input  logic [asbs_pkg::DATA_W-1:0]       pwdata,
  output logic [asbs_pkg::DATA_W-1:0]       prdata,
  output logic                              pready
);

  localparam int NT      = asbs_pkg::NUM_TRIALS;
  localparam int ANGLE_W = asbs_pkg::ANGLE_W;
  localparam int SINE_W  = asbs_pkg::SINE_W;
  localparam int SUM_W   = asbs_pkg::SUM_W;
  localparam int OUT_W   = asbs_pkg::OUT_W;
  localparam int GAIN_W  = asbs_pkg::GAIN_W;
  localparam int SIDE_W  = 1 + SINE_W + ANGLE_W;
  localparam int CP_W    = (SUM_W - 1) + GAIN_W;
  localparam logic signed [SUM_W-1:0] HP_S   = SUM_W'(asbs_pkg::HALF_PI);
  localparam logic signed [SUM_W-1:0] ONE_S  = SUM_W'(1) << asbs_pkg::FRAC;
  localparam logic signed [SUM_W-1:0] MAXOUT = (SUM_W'(1) << (asbs_pkg::FRAC + 1)) - SUM_W'(1);
  localparam logic [CP_W-1:0] GAIN_HALF = CP_W'(1) << (asbs_pkg::GAIN_FRAC_BITS - 1);

  // handshake and output buffering
  logic                   en;
  logic                   accept;
  logic                   deliver;
  logic                   out_valid;
  logic                   skid_valid;
  asbs_pkg::sample_out_t  out_data;
  asbs_pkg::sample_out_t  skid_data;

  // state
  logic [GAIN_W-1:0]        gain;
  logic signed [ANGLE_W-1:0] prev_angle;
  logic signed [OUT_W-1:0]  feedback_level;
  logic signed [OUT_W-1:0]  fb_next;

  // arcsine search: entry j holds the state before trial j
  logic                   dec_valid [0:NT];
  logic                   dec_neg   [0:NT];
  asbs_pkg::sine_t        dec_mag   [0:NT];
  asbs_pkg::angle_t       dec_angle [0:NT];

  asbs_pkg::angle_t       trial_c    [0:NT-1];
  logic [SIDE_W-1:0]      trial_side [0:NT-1];
  logic                   sv_valid   [0:NT-1];
  asbs_pkg::sine_t        sv_sine    [0:NT-1];
  logic [SIDE_W-1:0]      sv_side    [0:NT-1];
  logic                   keep_neg   [0:NT-1];
  asbs_pkg::sine_t        keep_mag   [0:NT-1];
  asbs_pkg::angle_t       keep_angle [0:NT-1];

  // slew stage
  logic signed [ANGLE_W-1:0] angle_s;
  logic signed [SUM_W-1:0]   diff;
  logic signed [SUM_W-1:0]   diff_c;
  logic                      d_valid;
  logic                      d_neg;
  asbs_pkg::angle_t          d_mag;
  logic                      f_valid;
  asbs_pkg::sine_t           f_sine;
  logic                      f_neg;

  // feedback sum
  logic signed [SUM_W-1:0]   sine_ext;
  logic signed [SUM_W-1:0]   sd;
  logic signed [SUM_W-1:0]   sum;
  logic [SUM_W-2:0]          sum_mag;
  logic [CP_W-1:0]           cprod;
  logic [CP_W-1:0]           crnd;
  logic signed [SUM_W-1:0]   cmag;
  logic signed [SUM_W-1:0]   fb_raw;
  asbs_pkg::sample_out_t     res;

  logic                              cfg_write;
  logic [asbs_pkg::REG_IDX_W-1:0]    reg_idx;

  assign en        = !(out_valid && skid_valid);
  assign din.ready = en && !rst;
  assign accept    = din.valid && din.ready;
  assign deliver   = en && f_valid;

  assign dout.valid      = out_valid;
  assign dout.sample_out = out_data;

  assign pready    = 1'b1;
  assign reg_idx   = paddr[asbs_pkg::ADDR_W-1:2];
  assign cfg_write = psel && penable && pwrite && pready && (reg_idx == asbs_pkg::REG_GAIN);

  always_comb begin
    prdata = '0;
    if (reg_idx == asbs_pkg::REG_GAIN) begin
      prdata = asbs_pkg::DATA_W'(gain);
    end
  end

  // arcsine trials
  always_comb begin
    for (int j = 0; j < NT; j++) begin
      trial_c[j]    = dec_angle[j] | (ANGLE_W'(1) << (NT - 1 - j));
      trial_side[j] = {dec_neg[j], dec_mag[j], dec_angle[j]};
      keep_neg[j]   = sv_side[j][SIDE_W-1];
      keep_mag[j]   = sv_side[j][ANGLE_W +: SINE_W];
      keep_angle[j] = sv_side[j][ANGLE_W-1:0];
      if (((keep_angle[j] | (ANGLE_W'(1) << (NT - 1 - j))) <= asbs_pkg::HALF_PI) &&
          (sv_sine[j] <= keep_mag[j])) begin
        keep_angle[j] = keep_angle[j] | (ANGLE_W'(1) << (NT - 1 - j));
      end
    end
  end

  for (genvar j = 0; j < NT; j++) begin : g_trial
    asbs_sine #(.SIDE_W(SIDE_W)) u_sine (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .in_valid (dec_valid[j]),
      .in_angle (trial_c[j]),
      .in_side  (trial_side[j]),
      .out_valid(sv_valid[j]),
      .out_sine (sv_sine[j]),
      .out_side (sv_side[j])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j <= NT; j++) begin
        dec_valid[j] <= 1'b0;
      end
    end else if (en) begin
      dec_valid[0] <= accept;
      for (int j = 0; j < NT; j++) begin
        dec_valid[j+1] <= sv_valid[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dec_neg[0]   <= din.sample_in[asbs_pkg::SAMPLE_BITS-1];
      dec_mag[0]   <= din.sample_in[asbs_pkg::SAMPLE_BITS-1] ? SINE_W'(-din.sample_in)
                                                             : SINE_W'(din.sample_in);
      dec_angle[0] <= '0;
      for (int j = 0; j < NT; j++) begin
        dec_neg[j+1]   <= keep_neg[j];
        dec_mag[j+1]   <= keep_mag[j];
        dec_angle[j+1] <= keep_angle[j];
      end
    end
  end

  // angle difference against the previous sample, clamped to +-pi/2
  always_comb begin
    angle_s = dec_neg[NT] ? -$signed(dec_angle[NT]) : $signed(dec_angle[NT]);
    diff    = SUM_W'(prev_angle) - SUM_W'(angle_s);
    diff_c  = diff;
    if (diff > HP_S) begin
      diff_c = HP_S;
    end else if (diff < -HP_S) begin
      diff_c = -HP_S;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_neg <= diff_c[SUM_W-1];
      d_mag <= diff_c[SUM_W-1] ? ANGLE_W'(-diff_c) : ANGLE_W'(diff_c);
    end
  end

  asbs_sine #(.SIDE_W(1)) u_slew_sine (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (d_valid),
    .in_angle (d_mag),
    .in_side  (d_neg),
    .out_valid(f_valid),
    .out_sine (f_sine),
    .out_side (f_neg)
  );

  // feedback sum and centering
  always_comb begin
    sine_ext = SUM_W'(f_sine);
    sd       = f_neg ? -sine_ext : sine_ext;
    sum      = SUM_W'(feedback_level) + sd;
    res      = (sum > MAXOUT) ? OUT_W'(MAXOUT) : OUT_W'(sum);
    sum_mag  = (SUM_W-1)'(sum[SUM_W-1] ? -sum : sum);
    cprod    = CP_W'(sum_mag) * CP_W'(gain);
    crnd     = cprod + GAIN_HALF;
    cmag     = SUM_W'(crnd >> asbs_pkg::GAIN_FRAC_BITS);
    fb_raw   = sum;
    if (gain < asbs_pkg::GAIN_ONE) begin
      fb_raw = sum[SUM_W-1] ? -cmag : cmag;
    end
    fb_next = OUT_W'(fb_raw);
    if (fb_raw > ONE_S) begin
      fb_next = OUT_W'(ONE_S);
    end else if (fb_raw < -ONE_S) begin
      fb_next = OUT_W'(-ONE_S);
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid      <= 1'b0;
      skid_valid     <= 1'b0;
      d_valid        <= 1'b0;
      prev_angle     <= '0;
      feedback_level <= '0;
      gain           <= asbs_pkg::GAIN_RESET;
    end else begin
      if (!out_valid || dout.ready) begin
        if (skid_valid) begin
          out_valid  <= 1'b1;
          skid_valid <= deliver;
        end else begin
          out_valid <= deliver;
        end
      end else if (deliver) begin
        skid_valid <= 1'b1;
      end
      if (en) begin
        d_valid <= dec_valid[NT];
      end
      if (en && dec_valid[NT]) begin
        prev_angle <= angle_s;
      end
      if (deliver) begin
        feedback_level <= fb_next;
      end
      if (cfg_write) begin
        gain <= pwdata[GAIN_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || dout.ready) begin
      out_data <= skid_valid ? skid_data : res;
    end else if (deliver) begin
      skid_data <= res;
    end
  end

endmodule

### design/asbs_checker.sv
// asbs_checker: port-level assertions for arcsine_slew_bus_summer_unit, attached by bind.
// Depends on asbs_pkg for port widths.

module asbs_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [asbs_pkg::OUT_W-1:0]    sample_out,
  input logic                          psel,
  input logic                          penable,
  input logic                          pwrite,
  input logic [asbs_pkg::ADDR_W-1:0]   paddr,
  input logic [asbs_pkg::DATA_W-1:0]   pwdata,
  input logic [asbs_pkg::DATA_W-1:0]   prdata
);

  localparam int GW = asbs_pkg::GAIN_W;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(sample_out))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result present after reset");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("request refused with empty output");

  a_gain_readback: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite && (paddr[asbs_pkg::ADDR_W-1:2] == asbs_pkg::REG_GAIN)
    |=> (paddr[asbs_pkg::ADDR_W-1:2] != asbs_pkg::REG_GAIN) ||
        (prdata == asbs_pkg::DATA_W'($past(pwdata[GW-1:0]))))
    else $error("gain readback mismatch");

endmodule

bind arcsine_slew_bus_summer_unit asbs_checker u_asbs_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (din.ready),
  .out_valid (dout.valid),
  .out_ready (dout.ready),
  .sample_out(dout.sample_out),
  .psel      (psel),
  .penable   (penable),
  .pwrite    (pwrite),
  .paddr     (paddr),
  .pwdata    (pwdata),
  .prdata    (prdata)
);

### tb/sv/slew_sum_check.sv
// Scoreboard for the arcsine slew bus summer: watches the sample channels and the APB
// writes, predicts each sample_out from its own copy of angle, feedback and gain.
// Depends on asbs_pkg and asbs_if (asbs_in_if, asbs_out_if).

module slew_sum_check (
  input  logic                        clk,
  input  logic                        rst,
  asbs_in_if                          din,
  asbs_out_if                         dout,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic                        pready,
  input  logic [asbs_pkg::ADDR_W-1:0] paddr,
  input  logic [asbs_pkg::DATA_W-1:0] pwdata,
  output int                          errors,
  output int                          pending,
  output int                          checked
);

  localparam int FRAC           = asbs_pkg::FRAC;
  localparam int Q30_SHIFT      = asbs_pkg::Q30_SHIFT;
  localparam int SAMPLE_BITS    = asbs_pkg::SAMPLE_BITS;
  localparam int GAIN_W         = asbs_pkg::GAIN_W;
  localparam int GAIN_FRAC_BITS = asbs_pkg::GAIN_FRAC_BITS;
  localparam int ADDR_W         = asbs_pkg::ADDR_W;
  localparam longint HALF_PI_FX = 13176795;
  localparam longint UNIT       = 64'sd1 << FRAC;
  localparam longint TOP_CODE   = (64'sd1 << (FRAC + 1)) - 1;
  localparam longint unsigned Q30_ONE = 64'd1 << 30;
  localparam longint unsigned TAYLOR_DIV [6] = '{156, 110, 72, 42, 20, 6};

  longint                 prev_angle;
  longint                 feedback;
  logic [GAIN_W-1:0]      gain;
  asbs_pkg::sample_out_t  out_due [$];
  asbs_pkg::sample_out_t  want;
  int                     err_n  = 0;
  int                     seen_n = 0;

  // sine of a nonnegative angle up to pi/2, sample scale, capped at 1.0
  function automatic longint unsigned sine_mag(input longint unsigned a);
    longint unsigned t, u, r, s;
    t = a << Q30_SHIFT;
    u = (t * t) >> 30;
    r = Q30_ONE;
    for (int i = 0; i < 6; i++)
      r = Q30_ONE - (((u * r) >> 30) / TAYLOR_DIV[i]);
    s = (((t * r) >> 30) + (64'd1 << (Q30_SHIFT - 1))) >> Q30_SHIFT;
    if (s > 64'(UNIT))
      s = 64'(UNIT);
    return s;
  endfunction

  function automatic longint unsigned arcsine_mag(input longint unsigned m);
    longint unsigned a, c;
    a = 0;
    for (int b = FRAC + 1; b >= 0; b--) begin
      c = a | (64'd1 << b);
      if (c <= 64'(HALF_PI_FX) && sine_mag(c) <= m)
        a = c;
    end
    return a;
  endfunction

  function automatic asbs_pkg::sample_out_t next_bus_sample(input asbs_pkg::sample_in_t s);
    logic [SAMPLE_BITS-1:0] raw;
    logic                   neg;
    longint unsigned        mag, m, p;
    longint                 angle, diff, sd, sum, res, fb;
    raw = s;
    neg = raw[FRAC];
    mag = neg ? ((64'd1 << SAMPLE_BITS) - 64'(raw)) : 64'(raw);
    angle = longint'(arcsine_mag(mag));
    if (neg)
      angle = -angle;
    diff = prev_angle - angle;
    if (diff > HALF_PI_FX)
      diff = HALF_PI_FX;
    if (diff < -HALF_PI_FX)
      diff = -HALF_PI_FX;
    prev_angle = angle;
    sd = longint'(sine_mag(64'(diff < 0 ? -diff : diff)));
    if (diff < 0)
      sd = -sd;
    sum = feedback + sd;
    res = (sum > TOP_CODE) ? TOP_CODE : sum;
    fb = sum;
    if (gain < asbs_pkg::GAIN_ONE) begin
      m = 64'(sum < 0 ? -sum : sum);
      p = (m * 64'(gain) + (64'd1 << (GAIN_FRAC_BITS - 1))) >> GAIN_FRAC_BITS;
      fb = (sum < 0) ? -longint'(p) : longint'(p);
    end
    if (fb > UNIT)
      fb = UNIT;
    if (fb < -UNIT)
      fb = -UNIT;
    feedback = fb;
    return asbs_pkg::sample_out_t'(res);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      prev_angle = 0;
      feedback   = 0;
      gain       = asbs_pkg::GAIN_RESET;
      out_due.delete();
    end else begin
      if (dout.valid && dout.ready) begin
        seen_n++;
        if (out_due.size() == 0) begin
          $error("sample_out: expected none, got %0d", dout.sample_out);
          err_n++;
        end else begin
          want = out_due.pop_front();
          if (dout.sample_out !== want) begin
            $error("sample_out: expected %0d, got %0d", want, dout.sample_out);
            err_n++;
          end
        end
      end
      if (din.valid && din.ready)
        out_due.push_back(next_bus_sample(din.sample_in));
      if (psel && penable && pwrite && pready && paddr[ADDR_W-1:2] == asbs_pkg::REG_GAIN)
        gain = pwdata[GAIN_W-1:0];
    end
    errors  <= err_n;
    pending <= out_due.size();
    checked <= seen_n;
  end

endmodule

### tb/sv/tb.sv
// Top of the arcsine slew bus summer testbench: clock, reset, sample requests with random
// idling, output stalls, APB gain writes and the verdict.
// Depends on asbs_pkg, asbs_if, arcsine_slew_bus_summer_unit and slew_sum_check.

module tb;

  localparam int ADDR_W          = asbs_pkg::ADDR_W;
  localparam int DATA_W          = asbs_pkg::DATA_W;
  localparam int GAIN_W          = asbs_pkg::GAIN_W;
  localparam int ITEMS_PER_PHASE = 240;
  localparam int NUM_PHASES      = 7;
  localparam int IDLE_LIMIT      = 4000;
  localparam int DRAIN_CYCLES    = 400;
  localparam int SPARE_IDX       = 1;
  localparam logic [ADDR_W-1:0] GAIN_ADDR  = ADDR_W'(asbs_pkg::REG_GAIN) << 2;
  localparam logic [ADDR_W-1:0] SPARE_ADDR = ADDR_W'(SPARE_IDX << 2);
  localparam int S_MAX = 2**asbs_pkg::FRAC - 1;
  localparam int S_MIN = -(2**asbs_pkg::FRAC);

  // reset-gain opener: full negative, then the run up to a +2.0 sum
  localparam int N_DIRECTED = 18;
  localparam int DIRECTED [N_DIRECTED] = '{-8388608, 8388607, -1448, -8388608, 0, 1, -1,
    4194304, -4194304, 8388607, -8388608, 2796202, -2796203, 5592405, 8384512, -8388607,
    2, 0};
  localparam int PHASE_GAIN [NUM_PHASES] = '{0, 1, 32768, 65535, 131071, 65536, 0};

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  psel, penable, pwrite, pready;
  logic [ADDR_W-1:0]     paddr;
  logic [DATA_W-1:0]     pwdata, prdata;
  int                    src_idle_pct, sink_stall_pct;
  int                    stall_left = 0;
  int                    quiet = 0;
  int                    errors, pending, checked;
  int                    sent = 0;
  asbs_pkg::sample_in_t  last_sample;

  asbs_in_if  din_ch ();
  asbs_out_if dout_ch ();

  always #2 clk = ~clk;

  arcsine_slew_bus_summer_unit u_dut (
    .clk     (clk),
    .rst     (rst),
    .din     (din_ch),
    .dout    (dout_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  slew_sum_check u_check (
    .clk     (clk),
    .rst     (rst),
    .din     (din_ch),
    .dout    (dout_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .pready  (pready),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .errors  (errors),
    .pending (pending),
    .checked (checked)
  );

  // output stalls in bursts, each started with probability sink_stall_pct percent
  always @(posedge clk) begin
    if (stall_left > 0) begin
      dout_ch.ready <= 1'b0;
      stall_left    <= stall_left - 1;
    end else if (int'($urandom_range(99)) < sink_stall_pct) begin
      dout_ch.ready <= 1'b0;
      stall_left    <= int'($urandom_range(14));
    end else begin
      dout_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (din_ch.valid && din_ch.ready) || (dout_ch.valid && dout_ch.ready) ||
        (psel && penable)) begin
      quiet <= 0;
    end else if (quiet == IDLE_LIMIT) begin
      $display("arcsine_slew_bus_summer_unit test failed");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic send_sample(input asbs_pkg::sample_in_t s);
    din_ch.valid     <= 1'b1;
    din_ch.sample_in <= s;
    do @(posedge clk); while (!din_ch.ready);
    sent++;
  endtask

  task automatic source_gap();
    if (int'($urandom_range(99)) < src_idle_pct) begin
      din_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  task automatic drain();
    din_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic reg_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  function automatic asbs_pkg::sample_in_t next_stimulus(input asbs_pkg::sample_in_t prev);
    int v;
    case ($urandom_range(9))
      0, 1, 2, 3: v = int'(asbs_pkg::sample_in_t'($urandom()));
      4: begin
        case ($urandom_range(4))
          0: v = S_MAX;
          1: v = S_MIN;
          2: v = 0;
          3: v = 1;
          default: v = -1;
        endcase
      end
      5, 6: v = int'(prev) + int'($urandom_range(8192)) - 4096;
      7: v = ($urandom_range(1) != 0) ? S_MAX - int'($urandom_range(4095))
                                       : S_MIN + int'($urandom_range(4095));
      8: v = ($urandom_range(1) != 0) ? int'($urandom_range(2047))
                                       : -int'($urandom_range(2047));
      default: v = -int'(prev);
    endcase
    if (v > S_MAX)
      v = S_MAX;
    if (v < S_MIN)
      v = S_MIN;
    return asbs_pkg::sample_in_t'(v);
  endfunction

  initial begin
    logic [DATA_W-1:0] wdata;
    rst              <= 1'b1;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= '0;
    din_ch.valid     <= 1'b0;
    din_ch.sample_in <= '0;
    src_idle_pct   = 20;
    sink_stall_pct = 20;
    last_sample    = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (int k = 0; k < N_DIRECTED; k++) begin
      send_sample(asbs_pkg::sample_in_t'(DIRECTED[k]));
      source_gap();
    end
    drain();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph == 3)
        reg_write(SPARE_ADDR, $urandom());
      wdata = $urandom();
      wdata[GAIN_W-1:0] = (ph == NUM_PHASES - 1) ? GAIN_W'($urandom_range(65536))
                                                  : GAIN_W'(PHASE_GAIN[ph]);
      reg_write(GAIN_ADDR, wdata);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (ph == NUM_PHASES - 1) begin
          src_idle_pct   = 0;
          sink_stall_pct = 0;
        end else if (i % 60 == 0) begin
          src_idle_pct   = 15 * int'($urandom_range(2));
          sink_stall_pct = 15 * int'($urandom_range(2));
        end
        last_sample = next_stimulus(last_sample);
        send_sample(last_sample);
        source_gap();
      end
      drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("%0d samples sent over reset gain and %0d written gain settings", sent,
             NUM_PHASES);
    $display("%0d results compared, %0d mismatches", checked, errors);
    if (errors == 0)
      $display("arcsine_slew_bus_summer_unit test passed");
    else
      $display("arcsine_slew_bus_summer_unit test failed");
    $finish;
  end

endmodule
